[src/assert_macros.svh]
// Assertion macros used by the checker file of the level bar.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pplb_pkg.sv]
// Package of the peak-to-peak level bar: payload types, codes, constants and FSM types.
package pplb_pkg;

   // Field widths
   localparam int CMD_W        = 2;
   localparam int SAMPLE_W     = 11;
   localparam int KEY_W        = 3;
   localparam int ROW_W        = 6;
   localparam int COLOR_W      = 24;
   localparam int LEVEL_W      = 10;
   localparam int WINDOW_W     = 16;
   localparam int RED_ROWS_W   = 7;
   localparam int TICKS_W      = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Default column height
   localparam int COLUMN_HEIGHT_DEF = 8;

   // Request kinds
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_KEY    = 2'd2;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_HIGH_UP   = 3'd0;
   localparam logic [KEY_W-1:0] KEY_HIGH_DOWN = 3'd1;
   localparam logic [KEY_W-1:0] KEY_LOW_UP    = 3'd2;
   localparam logic [KEY_W-1:0] KEY_LOW_DOWN  = 3'd3;
   localparam logic [KEY_W-1:0] KEY_LOW_PEAK  = 3'd4;
   localparam logic [KEY_W-1:0] KEY_HIGH_PEAK = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_ROWS     = 2'd1;

   // Constants
   localparam logic [SAMPLE_W-1:0]   SAMPLE_LIMIT   = 11'd1024;
   localparam logic [LEVEL_W-1:0]    BOUND_TOP      = 10'd1023;
   localparam logic [LEVEL_W-1:0]    KEY_STEP       = 10'd100;
   localparam logic [TICKS_W-1:0]    TICK_TOP       = 17'h1ffff;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 16'd50;
   localparam logic [RED_ROWS_W-1:0] RED_ROWS_RESET = 7'd6;
   localparam logic [COLOR_W-1:0]    COLOR_OFF      = 24'h000000;
   localparam logic [COLOR_W-1:0]    COLOR_GREEN    = 24'h00ff00;
   localparam logic [COLOR_W-1:0]    COLOR_RED      = 24'hff0000;

   // Request payload
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [SAMPLE_W-1:0] sample_value;
      logic [KEY_W-1:0]    key_code;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [ROW_W-1:0]   row_index;
      logic [COLOR_W-1:0] pixel_color;
      logic [LEVEL_W-1:0] peak_level;
      logic               last_row;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic prep;
      logic capture;
      logic row_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic close;
      logic bounds_equal;
      logic div_done;
      logic last_row;
   } status_type;

endpackage

[src/pplb_div.sv]
// Shift-subtract divider for unsigned magnitudes, one quotient bit per cycle.
module pplb_div #(
   parameter int NUM_W = 14,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One restoring step
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

[src/pplb_dp.sv]
// Datapath: window tracking, scale bounds, settings, level scaling and column pixels.
module pplb_dp #(
   parameter int COLUMN_HEIGHT = pplb_pkg::COLUMN_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pplb_pkg::req_type                  req_payload,
   input  logic                               csr_valid,
   input  logic [pplb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pplb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  pplb_pkg::cmd_type                  cmd,
   output pplb_pkg::status_type               status,
   output pplb_pkg::rsp_type                  rsp_payload
);

   localparam int LVL_W = $clog2(COLUMN_HEIGHT + 1);
   localparam int NUM_W = pplb_pkg::LEVEL_W + LVL_W;
   localparam int DEN_W = pplb_pkg::LEVEL_W;
   localparam int LW    = pplb_pkg::LEVEL_W;

   // Settings
   logic [pplb_pkg::WINDOW_W-1:0]   window_ticks_ff, window_ticks_in;
   logic [pplb_pkg::RED_ROWS_W-1:0] red_rows_ff, red_rows_in;

   // Window and scale state
   logic [LW-1:0]                   window_max_ff, window_max_in;
   logic [pplb_pkg::SAMPLE_W-1:0]   window_min_ff, window_min_in;
   logic [pplb_pkg::TICKS_W-1:0]    elapsed_ff, elapsed_in;
   logic [LW-1:0]                   last_peak_ff, last_peak_in;
   logic [LW-1:0]                   scale_low_ff, scale_low_in;
   logic [LW-1:0]                   scale_high_ff, scale_high_in;

   // Column state
   logic [LVL_W-1:0]                level_ff, level_in;
   logic [pplb_pkg::ROW_W-1:0]      row_ff, row_in;
   logic                            neg_ff, neg_in;

   logic [pplb_pkg::TICKS_W-1:0]    elapsed_next;
   logic                            close;
   logic [LW-1:0]                   peak;
   logic [LW:0]                     high_up, low_up;
   logic [LW-1:0]                   sample10;
   logic                            sample_ok;
   logic [LW:0]                     diff_pl, diff_hl;
   logic [LW-1:0]                   mag_pl, mag_hl;
   logic [NUM_W-1:0]                num_mag;
   logic [NUM_W-1:0]                quot;
   logic                            div_done;
   logic                            div_start;
   logic [LVL_W-1:0]                eq_level;
   logic [LVL_W-1:0]                div_level;
   logic                            row_lit;

   // Tick count with saturation and window close test
   assign elapsed_next = (elapsed_ff == pplb_pkg::TICK_TOP) ? elapsed_ff : elapsed_ff + 1'b1;
   assign close = (req_payload.cmd == pplb_pkg::CMD_TICK) &&
                  (elapsed_next > {1'b0, window_ticks_ff});

   // Peak-to-peak of the open window, zero when empty
   always_comb begin
      if (window_min_ff >= pplb_pkg::SAMPLE_LIMIT ||
          {1'b0, window_max_ff} < window_min_ff) begin
         peak = '0;
      end else begin
         peak = window_max_ff - window_min_ff[LW-1:0];
      end
   end

   assign sample_ok = req_payload.sample_value < pplb_pkg::SAMPLE_LIMIT;
   assign sample10  = req_payload.sample_value[LW-1:0];
   assign high_up   = {1'b0, scale_high_ff} + {1'b0, pplb_pkg::KEY_STEP};
   assign low_up    = {1'b0, scale_low_ff} + {1'b0, pplb_pkg::KEY_STEP};

   // Request handling
   always_comb begin
      window_max_in = window_max_ff;
      window_min_in = window_min_ff;
      elapsed_in    = elapsed_ff;
      last_peak_in  = last_peak_ff;
      scale_low_in  = scale_low_ff;
      scale_high_in = scale_high_ff;
      if (cmd.take) begin
         unique case (req_payload.cmd)
            pplb_pkg::CMD_SAMPLE: begin
               if (sample_ok) begin
                  if (sample10 > window_max_ff) window_max_in = sample10;
                  if (req_payload.sample_value < window_min_ff) begin
                     window_min_in = req_payload.sample_value;
                  end
               end
            end
            pplb_pkg::CMD_TICK: begin
               if (close) begin
                  elapsed_in    = '0;
                  last_peak_in  = peak;
                  window_max_in = '0;
                  window_min_in = pplb_pkg::SAMPLE_LIMIT;
               end else begin
                  elapsed_in = elapsed_next;
               end
            end
            pplb_pkg::CMD_KEY: begin
               unique case (req_payload.key_code)
                  pplb_pkg::KEY_HIGH_UP: begin
                     scale_high_in = (high_up > {1'b0, pplb_pkg::BOUND_TOP}) ?
                                     pplb_pkg::BOUND_TOP : high_up[LW-1:0];
                  end
                  pplb_pkg::KEY_HIGH_DOWN: begin
                     scale_high_in = (scale_high_ff < pplb_pkg::KEY_STEP) ?
                                     '0 : scale_high_ff - pplb_pkg::KEY_STEP;
                  end
                  pplb_pkg::KEY_LOW_UP: begin
                     scale_low_in = (low_up > {1'b0, pplb_pkg::BOUND_TOP}) ?
                                    pplb_pkg::BOUND_TOP : low_up[LW-1:0];
                  end
                  pplb_pkg::KEY_LOW_DOWN: begin
                     scale_low_in = (scale_low_ff < pplb_pkg::KEY_STEP) ?
                                    '0 : scale_low_ff - pplb_pkg::KEY_STEP;
                  end
                  pplb_pkg::KEY_LOW_PEAK:  scale_low_in  = last_peak_ff;
                  pplb_pkg::KEY_HIGH_PEAK: scale_high_in = last_peak_ff;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // Settings writes; unknown indexes are dropped
   always_comb begin
      window_ticks_in = window_ticks_ff;
      red_rows_in     = red_rows_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pplb_pkg::CSR_WINDOW_TICKS: window_ticks_in = csr_wdata;
            pplb_pkg::CSR_RED_ROWS:     red_rows_in = csr_wdata[pplb_pkg::RED_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Signed differences as sign and magnitude for the divider
   assign diff_pl = {1'b0, last_peak_ff} - {1'b0, scale_low_ff};
   assign diff_hl = {1'b0, scale_high_ff} - {1'b0, scale_low_ff};
   assign mag_pl  = diff_pl[LW] ? LW'(-diff_pl) : diff_pl[LW-1:0];
   assign mag_hl  = diff_hl[LW] ? LW'(-diff_hl) : diff_hl[LW-1:0];
   assign num_mag = NUM_W'(mag_pl) * NUM_W'(COLUMN_HEIGHT);
   assign div_start = cmd.prep && !status.bounds_equal;

   pplb_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag),
      .den   (mag_hl),
      .quot  (quot),
      .done  (div_done)
   );

   // Level: equal bounds give all or nothing; otherwise clamp the quotient
   assign eq_level  = (last_peak_ff > scale_low_ff) ? LVL_W'(COLUMN_HEIGHT) : '0;
   assign div_level = neg_ff ? '0 :
                      (quot > NUM_W'(COLUMN_HEIGHT)) ? LVL_W'(COLUMN_HEIGHT) :
                      quot[LVL_W-1:0];

   always_comb begin
      level_in = level_ff;
      row_in   = row_ff;
      neg_in   = neg_ff;
      if (cmd.prep) begin
         row_in   = '0;
         neg_in   = diff_pl[LW] ^ diff_hl[LW];
         level_in = eq_level;
      end else if (cmd.capture) begin
         level_in = div_level;
      end else if (cmd.row_step) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff <= pplb_pkg::WINDOW_RESET;
         red_rows_ff     <= pplb_pkg::RED_ROWS_RESET;
         window_max_ff   <= '0;
         window_min_ff   <= pplb_pkg::SAMPLE_LIMIT;
         elapsed_ff      <= '0;
         last_peak_ff    <= '0;
         scale_low_ff    <= '0;
         scale_high_ff   <= pplb_pkg::BOUND_TOP;
      end else begin
         window_ticks_ff <= window_ticks_in;
         red_rows_ff     <= red_rows_in;
         window_max_ff   <= window_max_in;
         window_min_ff   <= window_min_in;
         elapsed_ff      <= elapsed_in;
         last_peak_ff    <= last_peak_in;
         scale_low_ff    <= scale_low_in;
         scale_high_ff   <= scale_high_in;
      end
      level_ff <= level_in;
      row_ff   <= row_in;
      neg_ff   <= neg_in;
   end

   // Pixel of the current row
   assign row_lit = {{(8 - pplb_pkg::ROW_W){1'b0}}, row_ff} < 8'(level_ff);

   always_comb begin
      rsp_payload.row_index  = row_ff;
      rsp_payload.peak_level = last_peak_ff;
      rsp_payload.last_row   = status.last_row;
      if (!row_lit) begin
         rsp_payload.pixel_color = pplb_pkg::COLOR_OFF;
      end else if ({1'b0, row_ff} < red_rows_ff) begin
         rsp_payload.pixel_color = pplb_pkg::COLOR_GREEN;
      end else begin
         rsp_payload.pixel_color = pplb_pkg::COLOR_RED;
      end
   end

   assign status.close        = close;
   assign status.bounds_equal = scale_low_ff == scale_high_ff;
   assign status.div_done     = div_done;
   assign status.last_row     = row_ff == pplb_pkg::ROW_W'(COLUMN_HEIGHT - 1);

endmodule

[src/pplb_ctrl.sv]
// Controller: request intake, level computation sequencing and column transfer.
module pplb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_stall,
   input  pplb_pkg::status_type status,
   output pplb_pkg::cmd_type    cmd,
   output logic                 req_stall,
   output logic                 rsp_valid
);

   pplb_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pplb_pkg::ST_IDLE: begin
            if (req_valid && status.close) state_in = pplb_pkg::ST_PREP;
         end
         pplb_pkg::ST_PREP: begin
            state_in = status.bounds_equal ? pplb_pkg::ST_EMIT : pplb_pkg::ST_DIV;
         end
         pplb_pkg::ST_DIV: begin
            if (status.div_done) state_in = pplb_pkg::ST_EMIT;
         end
         pplb_pkg::ST_EMIT: begin
            if (!rsp_stall && status.last_row) state_in = pplb_pkg::ST_IDLE;
         end
         default: state_in = pplb_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         pplb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         pplb_pkg::ST_PREP: cmd.prep = 1'b1;
         pplb_pkg::ST_DIV:  cmd.capture = status.div_done;
         pplb_pkg::ST_EMIT: begin
            rsp_valid    = 1'b1;
            cmd.row_step = !rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pplb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/peak_to_peak_level_bar.sv]
// Peak-to-peak level bar: samples, ticks and keys in; one column of bar pixels per window out.
// Samples, key events and ticks that do not close the window are taken one per cycle while idle.
// A tick that closes the window is followed by a busy spell: a set-up state prepares the scaling,
// then, unless the scale bounds are equal, the shift-subtract divider works through the
// numerator bit by bit (10 + clog2(COLUMN_HEIGHT+1) bits, 14 at the default height) and then
// hands over its quotient. The column then leaves as COLUMN_HEIGHT results, one per cycle
// while rsp_stall is low, bottom row first, last_row marking the top. req_stall stays high
// from the closing tick until the last row is taken. Settings are written through the csr
// port, which is always ready; write it only while the block is idle.
module peak_to_peak_level_bar #(
   parameter int COLUMN_HEIGHT = pplb_pkg::COLUMN_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pplb_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pplb_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pplb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pplb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pplb_pkg::cmd_type    cmd;
   pplb_pkg::status_type status;

   assign csr_ready = 1'b1;

   pplb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   pplb_dp #(
      .COLUMN_HEIGHT(COLUMN_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/pplb_checker.sv]
// Port-level checks on the level bar and the bind that attaches them.
`include "assert_macros.svh"

module pplb_checker #(
   parameter int COLUMN_HEIGHT = pplb_pkg::COLUMN_HEIGHT_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pplb_pkg::rsp_type rsp_payload
);

   // No request is taken while a column is going out
   `ASSERT_IMPLY(a_busy_while_column, clock, reset, rsp_valid, req_stall,
                 "request open during column")

   // A column runs without gaps until its top row
   `ASSERT_NEXT(a_column_unbroken, clock, reset,
                rsp_valid && !rsp_stall && !rsp_payload.last_row, rsp_valid,
                "gap inside column")

   // Rows climb by one
   `ASSERT_NEXT(a_row_climbs, clock, reset,
                rsp_valid && !rsp_stall && !rsp_payload.last_row,
                rsp_payload.row_index ==
                pplb_pkg::ROW_W'($past(rsp_payload.row_index) + 1'b1),
                "row out of order")

   // Top row flag matches the row index
   `ASSERT_IMPLY(a_last_row_flag, clock, reset, rsp_valid,
                 rsp_payload.last_row ==
                 (rsp_payload.row_index == pplb_pkg::ROW_W'(COLUMN_HEIGHT - 1)),
                 "top row flag wrong")

endmodule

bind peak_to_peak_level_bar pplb_checker #(.COLUMN_HEIGHT(COLUMN_HEIGHT)) u_pplb_checker (.*);
